// File: rtl/tbccm_pkg.sv
// shared types and constants of the two-board coincidence map
`timescale 1ns / 1ps
`default_nettype none

package tbccm_pkg;

  localparam int unsigned BoardW    = 8;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned BinCountW = 32;

  localparam logic [BoardW-1:0] BoardReset = 8'd30;

  localparam logic [CfgIdxW-1:0] CfgFirstBoard  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondBoard = 8'd1;

  typedef enum logic [CmdW-1:0] {
    CMD_HIT  = 2'd0,
    CMD_EOE  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // operation kinds that travel through the queue
  typedef enum logic [0:0] {
    OP_EOE  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RDATA
  } back_st_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [BoardW-1:0] board_id;
    logic [ChanW-1:0]  channel_index;
    logic [ChanW-1:0]  read_row;
    logic [ChanW-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [BinCountW-1:0] bin_count;
    logic                 bin_saturated;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/tbccm_front.sv
// front end: config registers, per-event hit masks and command classification
`timescale 1ns / 1ps
`default_nettype none

module tbccm_front #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [tbccm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [tbccm_pkg::BoardW-1:0]         cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire tbccm_pkg::in_item_t                  in_item_i,
  input  wire logic                                 clear_busy_i,
  input  wire logic                                 q_full_i,
  output logic                                      push_o,
  output tbccm_pkg::op_e                            push_op_o,
  output logic                                      push_oob_o,
  output logic [$clog2(CHANNELS*CHANNELS)-1:0]      push_addr_o,
  output logic [CHANNELS-1:0]                       mask_a_o,
  output logic [CHANNELS-1:0]                       mask_b_o
);

  localparam int unsigned AW = $clog2(CHANNELS*CHANNELS);

  logic [tbccm_pkg::BoardW-1:0] first_board_q, second_board_q;
  logic [CHANNELS-1:0]          mask_a_q, mask_a_d, mask_b_q, mask_b_d;
  logic [tbccm_pkg::CmdW-1:0]   cmd;
  logic                         needs_queue, accept, chan_ok;
  logic [CHANNELS-1:0]          chan_bit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_board_q  <= tbccm_pkg::BoardReset;
      second_board_q <= tbccm_pkg::BoardReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tbccm_pkg::CfgFirstBoard) begin
        first_board_q <= cfg_data_i;
      end
      if (cfg_index_i == tbccm_pkg::CfgSecondBoard) begin
        second_board_q <= cfg_data_i;
      end
    end
  end

  assign cmd         = in_item_i.command;
  assign needs_queue = (cmd == tbccm_pkg::CMD_EOE) || (cmd == tbccm_pkg::CMD_READ);
  // hits never touch the queue, so only the clearing pass holds them off
  assign in_stall_o = clear_busy_i | (needs_queue & q_full_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign chan_ok  = 32'(in_item_i.channel_index) < CHANNELS;
  assign chan_bit = CHANNELS'(1) << in_item_i.channel_index;

  assign push_op_o   = (cmd == tbccm_pkg::CMD_READ) ? tbccm_pkg::OP_READ : tbccm_pkg::OP_EOE;
  assign push_oob_o  = !((32'(in_item_i.read_row) < CHANNELS) &&
                         (32'(in_item_i.read_col) < CHANNELS));
  assign push_addr_o = AW'(32'(in_item_i.read_row) * CHANNELS + 32'(in_item_i.read_col));
  assign mask_a_o    = mask_a_q;
  assign mask_b_o    = mask_b_q;

  always_comb begin
    mask_a_d = mask_a_q;
    mask_b_d = mask_b_q;
    push_o   = 1'b0;
    if (accept) begin
      unique case (tbccm_pkg::cmd_e'(cmd))
        tbccm_pkg::CMD_HIT: begin
          if (chan_ok) begin
            if (in_item_i.board_id == first_board_q) begin
              mask_a_d = mask_a_q | chan_bit;
            end
            if (in_item_i.board_id == second_board_q) begin
              mask_b_d = mask_b_q | chan_bit;
            end
          end
        end
        tbccm_pkg::CMD_EOE: begin
          // masks go along with the beat, next event starts empty
          push_o   = 1'b1;
          mask_a_d = '0;
          mask_b_d = '0;
        end
        tbccm_pkg::CMD_READ: begin
          push_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_a_q <= '0;
      mask_b_q <= '0;
    end else begin
      mask_a_q <= mask_a_d;
      mask_b_q <= mask_b_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tbccm_fifo.sv
// two-entry queue between front end and counter engine
`timescale 1ns / 1ps
`default_nettype none

module tbccm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/tbccm_back.sv
// counter engine: bin memory, clearing pass, end-of-event walk and bin reads
`timescale 1ns / 1ps
`default_nettype none

module tbccm_back #(
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned EW         = 2 + $clog2(CHANNELS*CHANNELS) + 2*CHANNELS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire logic [EW-1:0]   q_data_i,
  output logic                 q_pop_o,
  output logic                 clear_busy_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tbccm_pkg::out_item_t out_item_o
);

  localparam int unsigned DEPTH = CHANNELS * CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(CHANNELS);
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // queue entry fields
  tbccm_pkg::op_e      q_op;
  logic                q_oob;
  logic [AW-1:0]       q_addr;
  logic [CHANNELS-1:0] q_mask_a, q_mask_b;

  assign q_op     = tbccm_pkg::op_e'(q_data_i[EW-1]);
  assign q_oob    = q_data_i[EW-2];
  assign q_addr   = q_data_i[2*CHANNELS +: AW];
  assign q_mask_a = q_data_i[CHANNELS +: CHANNELS];
  assign q_mask_b = q_data_i[0 +: CHANNELS];

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q, mem_wdata, inc;
  logic                  rd_en, mem_we;
  logic [AW-1:0]         rd_addr, mem_waddr;

  tbccm_pkg::back_st_e st_q, st_d;
  logic [AW-1:0]       addr_q, addr_d, wr_addr_q, wr_addr_d;
  logic [RW-1:0]       r_q, r_d, c_q, c_d;
  logic [CHANNELS-1:0] mask_a_q, mask_a_d, mask_b_q, mask_b_d;
  logic                wr_pend_q, wr_pend_d;
  logic                last_row, last_col;

  logic                 out_valid_q, out_free, out_load, load_zero;
  tbccm_pkg::out_item_t out_item_q, out_item_d;

  assign clear_busy_o = (st_q == tbccm_pkg::ST_CLEAR);
  assign last_row     = (r_q == RW'(CHANNELS - 1));
  assign last_col     = (c_q == RW'(CHANNELS - 1));
  assign out_free     = ~out_valid_q | ~out_stall_i;

  // saturating increment of the bin read in the previous cycle
  assign inc       = (rdata_q == CntMax) ? rdata_q : rdata_q + COUNT_BITS'(1);
  assign mem_we    = clear_busy_o | wr_pend_q;
  assign mem_waddr = clear_busy_o ? addr_q : wr_addr_q;
  assign mem_wdata = clear_busy_o ? '0 : inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    st_d      = st_q;
    addr_d    = addr_q;
    r_d       = r_q;
    c_d       = c_q;
    mask_a_d  = mask_a_q;
    mask_b_d  = mask_b_q;
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = addr_q;
    wr_pend_d = 1'b0;
    wr_addr_d = addr_q;
    out_load  = 1'b0;
    load_zero = 1'b0;
    unique case (st_q)
      tbccm_pkg::ST_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == AW'(DEPTH - 1)) begin
          addr_d = '0;
          st_d   = tbccm_pkg::ST_IDLE;
        end
      end
      tbccm_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_op == tbccm_pkg::OP_EOE) begin
            q_pop_o  = 1'b1;
            mask_a_d = q_mask_a;
            mask_b_d = q_mask_b;
            r_d      = '0;
            c_d      = '0;
            addr_d   = '0;
            st_d     = tbccm_pkg::ST_WALK;
          end else if (out_free) begin
            q_pop_o = 1'b1;
            if (q_oob) begin
              out_load  = 1'b1;
              load_zero = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = q_addr;
              st_d    = tbccm_pkg::ST_RDATA;
            end
          end
        end
      end
      tbccm_pkg::ST_WALK: begin
        if (!mask_a_q[r_q]) begin
          // row without a first-board hit: skip it whole
          r_d    = r_q + RW'(1);
          c_d    = '0;
          addr_d = addr_q + AW'(CHANNELS);
          if (last_row) begin
            st_d = tbccm_pkg::ST_DRAIN;
          end
        end else begin
          rd_en     = mask_b_q[c_q];
          wr_pend_d = mask_b_q[c_q];
          wr_addr_d = addr_q;
          addr_d    = addr_q + AW'(1);
          if (last_col) begin
            c_d = '0;
            r_d = r_q + RW'(1);
            if (last_row) begin
              st_d = tbccm_pkg::ST_DRAIN;
            end
          end else begin
            c_d = c_q + RW'(1);
          end
        end
      end
      tbccm_pkg::ST_DRAIN: begin
        // last pending write lands here before any read
        st_d = tbccm_pkg::ST_IDLE;
      end
      tbccm_pkg::ST_RDATA: begin
        out_load = 1'b1;
        st_d     = tbccm_pkg::ST_IDLE;
      end
      default: begin
        st_d = tbccm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_item_d = out_item_q;
    if (out_load) begin
      out_item_d.bin_count     = load_zero ? '0 : tbccm_pkg::BinCountW'(rdata_q);
      out_item_d.bin_saturated = ~load_zero & (rdata_q == CntMax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tbccm_pkg::ST_CLEAR;
      addr_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      addr_q    <= addr_d;
      r_q       <= r_d;
      c_q       <= c_d;
      wr_pend_q <= wr_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_a_q   <= mask_a_d;
    mask_b_q   <= mask_b_d;
    wr_addr_q  <= wr_addr_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: rtl/two_board_channel_coincidence_map.sv
// Channel coincidence histogram between two boards. Hit beats set a bit in the per-event mask
// of the first and/or second board and are taken one per cycle outside the clearing pass. An
// end-of-event beat hands both masks to the counter engine through a two-entry queue and the
// masks restart empty; end-of-event and read beats stall while that queue is full. The engine
// pops an entry and then walks the bin memory with one read-modify-write port, visiting each bin
// of a row that has a first-board hit and skipping each row without one whole, then retires the
// last write in a drain state. A read beat that finds the engine idle and the queue empty shows
// its bin on out_valid_o after the queue, the memory read register and an output register (a bin
// out of range skips the memory read and reads as zero). Counters saturate at all ones. After
// reset a clearing pass zeroes the bin memory; in_stall_o stays high until it is done,
// configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module two_board_channel_coincidence_map #(
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tbccm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tbccm_pkg::BoardW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tbccm_pkg::in_item_t           in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tbccm_pkg::out_item_t               out_item_o
);

  localparam int unsigned AW = $clog2(CHANNELS*CHANNELS);
  localparam int unsigned EW = 2 + AW + 2*CHANNELS;

  logic                clear_busy, q_full, q_valid, q_pop, push, push_oob;
  tbccm_pkg::op_e      push_op;
  logic [AW-1:0]       push_addr;
  logic [CHANNELS-1:0] mask_a, mask_b;
  logic [EW-1:0]       push_data, q_data;

  tbccm_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .clear_busy_i(clear_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op),
    .push_oob_o  (push_oob),
    .push_addr_o (push_addr),
    .mask_a_o    (mask_a),
    .mask_b_o    (mask_b)
  );

  assign push_data = {push_op, push_oob, push_addr, mask_a, mask_b};

  tbccm_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  tbccm_back #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS),
    .EW        (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .clear_busy_o(clear_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // no beat gets in while the bin memory is being cleared
  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> in_stall_o)
    else $error("input accepted during clearing pass");

  // the front end never pushes into a full queue
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue overflow");

  // the engine only pops from a queue that holds an entry
  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a saturated bin reports an all-ones count
  a_sat_means_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.bin_saturated) |->
      (out_item_o.bin_count == tbccm_pkg::BinCountW'({COUNT_BITS{1'b1}})))
    else $error("saturated flag without maximum count");

endmodule

`default_nettype wire

// File: tb/sv/tb_two_board_channel_coincidence_map.sv
// self-checking testbench for the two-board channel coincidence map
`timescale 1ns / 1ps

module tb_two_board_channel_coincidence_map;

  localparam int unsigned Chans       = 16;
  localparam int unsigned DrainCycles = 800;   // two queued walks, one running, plus a read
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned IdlePct     = 37;

  localparam logic [tbccm_pkg::CmdW-1:0]    CmdSpare    = 2'd3;
  localparam logic [tbccm_pkg::CfgIdxW-1:0] CfgNoSuchReg = 8'hFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_valid = 1'b0;
  logic [tbccm_pkg::CfgIdxW-1:0]    cfg_index = '0;
  logic [tbccm_pkg::BoardW-1:0]     cfg_data = '0;
  logic                             cfg_ready_o;
  logic                             in_valid = 1'b0;
  tbccm_pkg::in_item_t              in_item = '0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             out_stall = 1'b0;
  tbccm_pkg::out_item_t             out_item_o;

  two_board_channel_coincidence_map uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // histogram predictor state
  logic [tbccm_pkg::BoardW-1:0]    row_board = tbccm_pkg::BoardReset;
  logic [tbccm_pkg::BoardW-1:0]    col_board = tbccm_pkg::BoardReset;
  logic [Chans-1:0]                row_hits = '0;
  logic [Chans-1:0]                col_hits = '0;
  logic [tbccm_pkg::BinCountW-1:0] bin_tally [Chans*Chans];

  tbccm_pkg::in_item_t  pending_beats [$];
  tbccm_pkg::out_item_t bin_reads_due [$];
  tbccm_pkg::out_item_t due_bin;

  logic calm = 1'b0;
  int   n_queued = 0;
  int   n_beats = 0;
  int   n_events = 0;
  int   n_reads_checked = 0;
  int   n_errors = 0;
  int   quiet_cycles = 0;

  task automatic report_mismatch(input string what,
                                 input logic [tbccm_pkg::BinCountW-1:0] got,
                                 input logic [tbccm_pkg::BinCountW-1:0] want);
    $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  task automatic tally_beat(input tbccm_pkg::in_item_t b);
    tbccm_pkg::out_item_t rd;
    case (b.command)
      tbccm_pkg::CMD_HIT: begin
        if (b.board_id == row_board) row_hits[b.channel_index] = 1'b1;
        if (b.board_id == col_board) col_hits[b.channel_index] = 1'b1;
      end
      tbccm_pkg::CMD_EOE: begin
        for (int r = 0; r < Chans; r++) begin
          for (int c = 0; c < Chans; c++) begin
            if (row_hits[r] && col_hits[c] && bin_tally[r*Chans+c] != '1) begin
              bin_tally[r*Chans+c] = bin_tally[r*Chans+c] + 1'b1;
            end
          end
        end
        row_hits = '0;
        col_hits = '0;
        n_events++;
      end
      tbccm_pkg::CMD_READ: begin
        rd.bin_count     = bin_tally[b.read_row*Chans+b.read_col];
        rd.bin_saturated = (rd.bin_count == '1);
        bin_reads_due.push_back(rd);
      end
      default: ;  // spare code does nothing
    endcase
  endtask

  // driver: one beat per handshake, payload held while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        tally_beat(in_item);
        n_beats++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid <= 1'b1;
          in_item  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (bin_reads_due.size() == 0) begin
        report_mismatch("unexpected bin read", out_item_o.bin_count, '0);
      end else begin
        due_bin = bin_reads_due.pop_front();
        n_reads_checked++;
        if (out_item_o.bin_count !== due_bin.bin_count) begin
          report_mismatch("bin_count", out_item_o.bin_count, due_bin.bin_count);
        end
        if (out_item_o.bin_saturated !== due_bin.bin_saturated) begin
          report_mismatch("bin_saturated",
                          tbccm_pkg::BinCountW'(out_item_o.bin_saturated),
                          tbccm_pkg::BinCountW'(due_bin.bin_saturated));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: timeout, %0d bin reads still outstanding", bin_reads_due.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [tbccm_pkg::CfgIdxW-1:0] idx,
                           input logic [tbccm_pkg::BoardW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == tbccm_pkg::CfgFirstBoard) row_board = data;
    else if (idx == tbccm_pkg::CfgSecondBoard) col_board = data;
  endtask

  function automatic tbccm_pkg::in_item_t noise_beat();
    tbccm_pkg::in_item_t b;
    b.command       = tbccm_pkg::CmdW'($urandom_range(0, 3));
    b.board_id      = tbccm_pkg::BoardW'($urandom);
    b.channel_index = tbccm_pkg::ChanW'($urandom);
    b.read_row      = tbccm_pkg::ChanW'($urandom);
    b.read_col      = tbccm_pkg::ChanW'($urandom);
    return b;
  endfunction

  task automatic queue_beat(input tbccm_pkg::in_item_t b);
    pending_beats.push_back(b);
    n_queued++;
  endtask

  task automatic queue_hit(input logic [tbccm_pkg::BoardW-1:0] board,
                           input logic [tbccm_pkg::ChanW-1:0] ch);
    tbccm_pkg::in_item_t b;
    b               = noise_beat();
    b.command       = tbccm_pkg::CMD_HIT;
    b.board_id      = board;
    b.channel_index = ch;
    queue_beat(b);
  endtask

  task automatic queue_eoe();
    tbccm_pkg::in_item_t b;
    b         = noise_beat();
    b.command = tbccm_pkg::CMD_EOE;
    queue_beat(b);
  endtask

  task automatic queue_read(input logic [tbccm_pkg::ChanW-1:0] row,
                            input logic [tbccm_pkg::ChanW-1:0] col);
    tbccm_pkg::in_item_t b;
    b          = noise_beat();
    b.command  = tbccm_pkg::CMD_READ;
    b.read_row = row;
    b.read_col = col;
    queue_beat(b);
  endtask

  // mostly well-formed events with random content, the rest loose noise
  task automatic queue_random_events(input int count);
    int                           start;
    int                           roll;
    logic [tbccm_pkg::BoardW-1:0] board;
    start = n_queued;
    while (n_queued - start < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        queue_beat(noise_beat());
      end else if (roll < 24) begin
        // every channel of both boards in one event
        for (int ch = 0; ch < Chans; ch++) queue_hit(row_board, tbccm_pkg::ChanW'(ch));
        for (int ch = 0; ch < Chans; ch++) queue_hit(col_board, tbccm_pkg::ChanW'(ch));
        queue_eoe();
        queue_read(tbccm_pkg::ChanW'($urandom), tbccm_pkg::ChanW'($urandom));
      end else begin
        repeat ($urandom_range(0, 7)) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) board = row_board;
          else if (roll < 90) board = col_board;
          else board = tbccm_pkg::BoardW'($urandom);
          queue_hit(board, tbccm_pkg::ChanW'($urandom));
        end
        queue_eoe();
        repeat ($urandom_range(0, 2)) begin
          queue_read(tbccm_pkg::ChanW'($urandom), tbccm_pkg::ChanW'($urandom));
        end
      end
    end
  endtask

  // sender holds off until every read is back and the counter walks have retired
  task automatic drain_all();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk_i);
    while (bin_reads_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    tbccm_pkg::in_item_t b;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset boards, both masks fed by the same board
    queue_read('0, '0);
    queue_read('1, '1);
    queue_hit(tbccm_pkg::BoardReset, '0);
    queue_hit(tbccm_pkg::BoardReset, '1);
    queue_hit(tbccm_pkg::BoardReset + 8'd1, 4'd5);
    queue_hit(8'h00, 4'd3);
    queue_hit(8'hFF, 4'd7);
    b         = noise_beat();
    b.command = CmdSpare;
    queue_beat(b);
    queue_eoe();
    queue_read('0, '1);
    queue_read('1, '0);
    queue_read('1, '1);
    queue_read(4'd5, 4'd5);
    queue_eoe();  // empty event
    queue_read('0, '0);
    queue_hit(tbccm_pkg::BoardReset, '0);
    queue_hit(tbccm_pkg::BoardReset, '0);
    queue_eoe();
    queue_read('0, '0);
    drain_all();

    write_reg(tbccm_pkg::CfgFirstBoard, 8'h00);
    write_reg(tbccm_pkg::CfgSecondBoard, 8'hFF);
    write_reg(CfgNoSuchReg, 8'h5A);
    queue_random_events(258);
    drain_all();

    write_reg(tbccm_pkg::CfgFirstBoard, 8'hFF);
    write_reg(tbccm_pkg::CfgSecondBoard, 8'h00);
    calm <= 1'b1;
    queue_random_events(258);
    drain_all();
    calm <= 1'b0;

    write_reg(tbccm_pkg::CfgFirstBoard, 8'd7);
    write_reg(tbccm_pkg::CfgSecondBoard, 8'd7);
    queue_random_events(258);
    drain_all();

    write_reg(tbccm_pkg::CfgFirstBoard, tbccm_pkg::BoardW'($urandom_range(0, 255)));
    write_reg(tbccm_pkg::CfgSecondBoard, tbccm_pkg::BoardW'($urandom_range(0, 255)));
    queue_random_events(258);
    drain_all();

    $display("tb: %0d beats sent over five board settings, %0d events closed",
             n_beats, n_events);
    $display("tb: %0d bin reads checked, %0d mismatches", n_reads_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tbccm_pkg.sv
rtl/tbccm_front.sv
rtl/tbccm_fifo.sv
rtl/tbccm_back.sv
rtl/two_board_channel_coincidence_map.sv
tb/sv/tb_two_board_channel_coincidence_map.sv
